FILE: hdl/huffman_tree_bit_decoder_macros.svh
// assertion macros shared by the huffman tree bit decoder rtl
`ifndef HUFFMAN_TREE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define HTBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define HTBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/htbd_pkg.sv
// shared types and constants of the huffman tree bit decoder
package htbd_pkg;

    localparam logic [1:0] ST_SYMBOL = 2'd0;
    localparam logic [1:0] ST_LOADED = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [7:0] MARKER_RESET = 8'd43;

    typedef struct packed {
        logic rd;
        logic wr_node;
        logic wr_right;
    } t_mem_ctl;

endpackage

FILE: hdl/huffman_tree_bit_decoder.sv
// top level: preorder tree loader and bit-serial huffman tree walk decoder
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  request | in        | i_valid / o_stall  | i_operation, i_tree_byte, i_code_bit
//  result  | out       | o_valid / i_stall  | o_status, o_symbol
//  config  | in        | i_cfg_wr_en        | i_cfg_wr_data (internal marker)
//
//  one request per cycle while o_stall is low; a result passes through the stage register, then the output register
//  each code bit costs one read of the node store, the walk runs on the read data directly
//  left children are implicit (parent + 1), the pending right slots are chained in the node store
//  synchronous reset clears control only; node store is undefined until a tree is loaded
//  o_stall rises only when the stage register and the output register are both full
`include "huffman_tree_bit_decoder_macros.svh"

module huffman_tree_bit_decoder
    import htbd_pkg::*;
#(
    parameter int MAX_NODES   = 511,
    parameter int STACK_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_operation,
    input  logic [7:0] i_tree_byte,
    input  logic       i_code_bit,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_symbol,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    localparam int IW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int CW  = $clog2(STACK_DEPTH + 3);
    localparam int FW  = (IW > 8) ? IW : 8;

    logic [7:0]     r_marker;
    logic [NCW-1:0] r_node_count, n_node_count;
    logic [CW-1:0]  r_stack_count, n_stack_count;
    logic           r_tree_ready, n_tree_ready;
    logic           r_lp, n_lp;
    logic [IW-1:0]  r_top, n_top;
    logic [IW-1:0]  r_root_right, n_root_right;
    logic           r_root_leaf, n_root_leaf;
    logic [7:0]     r_root_sym, n_root_sym;
    logic [IW-1:0]  r_cur_idx, n_cur_idx;
    logic [IW-1:0]  r_cur_right, n_cur_right;
    logic           r_s1_valid, n_s1_valid;
    logic           r_s1_pend, n_s1_pend;
    logic [1:0]     r_s1_status, n_s1_status;
    logic [7:0]     r_s1_symbol, n_s1_symbol;
    logic [IW-1:0]  r_walk_idx, n_walk_idx;
    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [7:0]     r_out_symbol;

    t_mem_ctl       mem_ctl;
    logic [FW:0]    wr_node_data;
    logic [IW-1:0]  rd_addr;
    logic [FW:0]    rd_node;
    logic [IW-1:0]  rd_right;

    logic           out_free;
    logic           accept;
    logic           s1_leaf;
    logic [IW-1:0]  cur_idx, cur_right, step_next;
    logic [NCW-1:0] ld_n;
    logic [IW-1:0]  ld_idx;
    logic [CW-1:0]  ld_c, c1, c2;
    logic           ld_lp, pop, pop_right, is_marker, full_err, stk_err;
    logic [IW-1:0]  tp1;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_s1_valid && !out_free;
    assign accept   = i_valid && !o_stall;
    assign s1_leaf  = rd_node[FW];

    // current walk node, taken from the read data while a bit is in flight, or the root once a leaf is read
    always_comb begin
        if (r_s1_valid && r_s1_pend) begin
            if (s1_leaf) begin
                cur_idx   = '0;
                cur_right = r_root_right;
            end else begin
                cur_idx   = r_walk_idx;
                cur_right = rd_right;
            end
        end else begin
            cur_idx   = r_cur_idx;
            cur_right = r_cur_right;
        end
        step_next = i_code_bit ? cur_right : (cur_idx + IW'(1));
    end

    // load path
    always_comb begin
        ld_n      = r_tree_ready ? '0 : r_node_count;
        ld_c      = r_tree_ready ? '0 : r_stack_count;
        ld_lp     = r_tree_ready ? 1'b0 : r_lp;
        ld_idx    = ld_n[IW-1:0];
        is_marker = (i_tree_byte == r_marker);
        pop       = (ld_n != '0);
        pop_right = pop && !ld_lp;
        c1        = pop ? (ld_c - CW'(1)) : ld_c;
        tp1       = pop_right ? rd_node[IW-1:0] : r_top;
        full_err  = (ld_n >= NCW'(MAX_NODES));
        stk_err   = is_marker && ((c1 + CW'(2)) > CW'(STACK_DEPTH));
        c2        = is_marker ? (c1 + CW'(2)) : c1;
    end

    always_comb begin
        n_node_count  = r_node_count;
        n_stack_count = r_stack_count;
        n_tree_ready  = r_tree_ready;
        n_lp          = r_lp;
        n_top         = r_top;
        n_root_right  = r_root_right;
        n_root_leaf   = r_root_leaf;
        n_root_sym    = r_root_sym;
        n_cur_idx     = r_cur_idx;
        n_cur_right   = r_cur_right;
        n_s1_valid    = r_s1_valid;
        n_s1_pend     = r_s1_pend;
        n_s1_status   = r_s1_status;
        n_s1_symbol   = r_s1_symbol;
        n_walk_idx    = r_walk_idx;
        mem_ctl.rd       = !o_stall;
        mem_ctl.wr_node  = 1'b0;
        mem_ctl.wr_right = 1'b0;
        wr_node_data  = is_marker ? {1'b0, FW'(tp1)} : {1'b1, FW'(i_tree_byte)};
        rd_addr       = r_top;

        if (!o_stall) begin
            n_cur_idx   = cur_idx;
            n_cur_right = cur_right;
            n_s1_valid  = 1'b0;
        end

        if (accept) begin
            n_s1_pend   = 1'b0;
            n_s1_symbol = 8'd0;
            if (i_operation == OP_LOAD) begin
                if (full_err || stk_err) begin
                    n_node_count  = '0;
                    n_stack_count = '0;
                    n_tree_ready  = 1'b0;
                    n_lp          = 1'b0;
                    n_s1_valid    = 1'b1;
                    n_s1_status   = ST_ERROR;
                end else begin
                    mem_ctl.wr_node  = 1'b1;
                    mem_ctl.wr_right = pop_right;
                    n_node_count  = ld_n + NCW'(1);
                    n_stack_count = c2;
                    n_lp          = is_marker;
                    n_top         = is_marker ? ld_idx : tp1;
                    if (pop_right && (r_top == '0)) begin
                        n_root_right = ld_idx;
                    end
                    if (ld_n == '0) begin
                        n_root_leaf = !is_marker;
                        n_root_sym  = i_tree_byte;
                    end
                    n_tree_ready = (c2 == '0);
                    if (c2 == '0) begin
                        n_s1_valid  = 1'b1;
                        n_s1_status = ST_LOADED;
                        n_cur_idx   = '0;
                        n_cur_right = n_root_right;
                    end
                end
                rd_addr = n_top;
            end else begin
                if (!r_tree_ready) begin
                    n_s1_valid  = 1'b1;
                    n_s1_status = ST_ERROR;
                end else if (r_root_leaf) begin
                    n_s1_valid  = 1'b1;
                    n_s1_status = ST_SYMBOL;
                    n_s1_symbol = r_root_sym;
                end else begin
                    n_s1_valid  = 1'b1;
                    n_s1_pend   = 1'b1;
                    n_s1_status = ST_SYMBOL;
                    n_walk_idx  = step_next;
                    rd_addr     = step_next;
                end
            end
        end
    end

    htbd_node_store #(
        .DEPTH (MAX_NODES),
        .IW    (IW),
        .FW    (FW)
    ) u_node_store (
        .i_clk           (i_clk),
        .i_ctl           (mem_ctl),
        .i_wr_node_addr  (ld_idx),
        .i_wr_node_data  (wr_node_data),
        .i_wr_right_addr (r_top),
        .i_wr_right_data (ld_idx),
        .i_rd_addr       (rd_addr),
        .o_rd_node       (rd_node),
        .o_rd_right      (rd_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker      <= MARKER_RESET;
            r_node_count  <= '0;
            r_stack_count <= '0;
            r_tree_ready  <= 1'b0;
            r_lp          <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_s1_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_marker <= i_cfg_wr_data;
            end
            r_node_count  <= n_node_count;
            r_stack_count <= n_stack_count;
            r_tree_ready  <= n_tree_ready;
            r_lp          <= n_lp;
            r_s1_valid    <= n_s1_valid;
            r_s1_pend     <= n_s1_pend;
            if (out_free) begin
                r_out_valid <= r_s1_valid && (!r_s1_pend || s1_leaf);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_root_right <= n_root_right;
        r_root_leaf  <= n_root_leaf;
        r_root_sym   <= n_root_sym;
        r_cur_idx    <= n_cur_idx;
        r_cur_right  <= n_cur_right;
        r_s1_status  <= n_s1_status;
        r_s1_symbol  <= n_s1_symbol;
        r_walk_idx   <= n_walk_idx;
        if (out_free) begin
            r_out_status <= r_s1_status;
            r_out_symbol <= r_s1_pend ? rd_node[7:0] : r_s1_symbol;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_symbol = r_out_symbol;

    `HTBD_ASSERT_NOW(a_ready_stack_empty, r_tree_ready, r_stack_count == '0, "tree ready with pending slots")
    `HTBD_ASSERT_NOW(a_left_slot_counted, r_lp, r_stack_count != '0, "left slot pending with empty count")
    `HTBD_ASSERT_NOW(a_walk_needs_tree, r_s1_valid && r_s1_pend, r_tree_ready && !r_root_leaf, "walk read without a multi-node tree")
    `HTBD_ASSERT_NEXT(a_load_restarts, accept && (i_operation == OP_LOAD) && r_tree_ready, r_node_count == NCW'(1), "load on ready tree did not restart")
    `HTBD_ASSERT_NOW(a_symbol_zero, o_valid && (o_status != ST_SYMBOL), o_symbol == 8'd0, "symbol not zero on status result")

endmodule

FILE: hdl/htbd_node_store.sv
// node store: node entry memory with write forwarding and right-link memory
module htbd_node_store
    import htbd_pkg::*;
#(
    parameter int DEPTH = 511,
    parameter int IW    = 9,
    parameter int FW    = 9
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [IW-1:0] i_wr_node_addr,
    input  logic [FW:0]   i_wr_node_data,
    input  logic [IW-1:0] i_wr_right_addr,
    input  logic [IW-1:0] i_wr_right_data,
    input  logic [IW-1:0] i_rd_addr,
    output logic [FW:0]   o_rd_node,
    output logic [IW-1:0] o_rd_right
);

    logic [FW:0]   r_node_mem  [DEPTH];
    logic [IW-1:0] r_right_mem [DEPTH];
    logic [FW:0]   r_rd_node;
    logic [IW-1:0] r_rd_right;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_node) begin
            r_node_mem[i_wr_node_addr] <= i_wr_node_data;
        end
        if (i_ctl.wr_right) begin
            r_right_mem[i_wr_right_addr] <= i_wr_right_data;
        end
        if (i_ctl.rd) begin
            if (i_ctl.wr_node && (i_wr_node_addr == i_rd_addr)) begin
                r_rd_node <= i_wr_node_data;
            end else begin
                r_rd_node <= r_node_mem[i_rd_addr];
            end
            r_rd_right <= r_right_mem[i_rd_addr];
        end
    end

    assign o_rd_node  = r_rd_node;
    assign o_rd_right = r_rd_right;

endmodule
